// File: hdl/trss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trss_pkg
// Shared constants and conversion functions for the temperature reading to
// seven-segment converter.
// ----------------------------------------------------------------------------
package trss_pkg;

    localparam int RAW_W   = 8;
    localparam int SEG_W   = 8;
    localparam int DIGIT_W = 4;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [SEG_W-1:0]   seg_t;

    localparam seg_t SEG_DP    = 8'h01;
    localparam seg_t SEG_MINUS = 8'h02;
    localparam seg_t SEG_BLANK = 8'h00;

    // Segment code of one decimal digit, bit 7 is segment a.
    function automatic seg_t seg_code(input digit_t d);
        seg_t s;
        case (d)
            4'd0:    s = 8'hfc;
            4'd1:    s = 8'h60;
            4'd2:    s = 8'hda;
            4'd3:    s = 8'hf2;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'hb6;
            4'd6:    s = 8'hbe;
            4'd7:    s = 8'he0;
            4'd8:    s = 8'hfe;
            4'd9:    s = 8'hf6;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    // Fraction nibble times 625 in four BCD digits.
    function automatic logic [15:0] frac_bcd(input logic [3:0] nib);
        logic [15:0] b;
        case (nib)
            4'd0:    b = 16'h0000;
            4'd1:    b = 16'h0625;
            4'd2:    b = 16'h1250;
            4'd3:    b = 16'h1875;
            4'd4:    b = 16'h2500;
            4'd5:    b = 16'h3125;
            4'd6:    b = 16'h3750;
            4'd7:    b = 16'h4375;
            4'd8:    b = 16'h5000;
            4'd9:    b = 16'h5625;
            4'd10:   b = 16'h6250;
            4'd11:   b = 16'h6875;
            4'd12:   b = 16'h7500;
            4'd13:   b = 16'h8125;
            4'd14:   b = 16'h8750;
            4'd15:   b = 16'h9375;
            default: b = 16'h0000;
        endcase
        return b;
    endfunction

    // Shift-and-add-3 conversion of an 8-bit value into three BCD digits.
    function automatic logic [11:0] int_bcd(input logic [7:0] v);
        logic [11:0] b;
        b = 12'h000;
        for (int i = 7; i >= 0; i--) begin
            if (b[3:0] >= 4'd5) b[3:0] = b[3:0] + 4'd3;
            if (b[7:4] >= 4'd5) b[7:4] = b[7:4] + 4'd3;
            if (b[11:8] >= 4'd5) b[11:8] = b[11:8] + 4'd3;
            b = {b[10:0], v[i]};
        end
        return b;
    endfunction

endpackage

// File: hdl/temp_reading_to_seven_segment.sv
`timescale 1ns / 1ps
// Pipeline: three register stages (magnitude, BCD split, segment encode) each
// hold one request and move while the next is free; a request passes them in order.
// Throughput: one request per cycle while the output is not stalled.
// Reset: rst_n clears all stage valid bits asynchronously; payload is not reset.
// ----------------------------------------------------------------------------
// temp_reading_to_seven_segment
// Converts a two's-complement reading in sixteenths of a degree into eight
// seven-segment patterns with leading-zero blanking and a minus sign.
// ----------------------------------------------------------------------------
module temp_reading_to_seven_segment
    import trss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             raw_valid,
    output logic             raw_stall,
    input  logic [RAW_W-1:0] raw_low,
    input  logic [RAW_W-1:0] raw_high,
    output logic             seg_valid,
    input  logic             seg_stall,
    output logic [SEG_W-1:0] frac_seg_0,
    output logic [SEG_W-1:0] frac_seg_1,
    output logic [SEG_W-1:0] frac_seg_2,
    output logic [SEG_W-1:0] frac_seg_3,
    output logic [SEG_W-1:0] units_seg,
    output logic [SEG_W-1:0] tens_seg,
    output logic [SEG_W-1:0] hundreds_seg,
    output logic [SEG_W-1:0] sign_seg
);

    // Stage enables: a stage loads when it is empty or its content moves on.
    logic en1, en2, en3;

    logic        v1_reg, v2_reg, v3_reg;

    // Stage 1: magnitude split into fraction nibble and integer byte.
    logic [3:0]  nib_reg,  nib_next;
    logic [7:0]  ip_reg,   ip_next;
    logic        neg1_reg;

    // Stage 2: BCD digits.
    logic [15:0] fbcd_reg, fbcd_next;
    logic [11:0] ibcd_reg, ibcd_next;
    logic        neg2_reg;

    // Stage 3: segment patterns.
    seg_t        f0_reg, f1_reg, f2_reg, f3_reg;
    seg_t        u_reg, t_reg, h_reg, s_reg;
    seg_t        f0_next, f1_next, f2_next, f3_next;
    seg_t        u_next, t_next, h_next, s_next;

    logic [15:0] raw;
    logic [15:0] mag;

    assign en3       = !v3_reg || !seg_stall;
    assign en2       = !v2_reg || en3;
    assign en1       = !v1_reg || en2;
    assign raw_stall = !en1;

    always_comb
    begin
        raw      = {raw_high, raw_low};
        mag      = raw_high[7] ? (16'h0000 - raw) : raw;
        nib_next = mag[3:0];
        ip_next  = mag[11:4];
    end

    always_comb
    begin
        fbcd_next = frac_bcd(nib_reg);
        ibcd_next = int_bcd(ip_reg);
    end

    always_comb
    begin
        f0_next = seg_code(fbcd_reg[3:0]);
        f1_next = seg_code(fbcd_reg[7:4]);
        f2_next = seg_code(fbcd_reg[11:8]);
        f3_next = seg_code(fbcd_reg[15:12]);
        u_next  = seg_code(ibcd_reg[3:0]) | SEG_DP;
        // Tens shows when the value reaches ten, which the upper digits tell.
        t_next  = (ibcd_reg[11:4] != 8'h00) ? seg_code(ibcd_reg[7:4]) : SEG_BLANK;
        h_next  = (ibcd_reg[11:8] != 4'h0) ? seg_code(ibcd_reg[11:8]) : SEG_BLANK;
        s_next  = neg2_reg ? SEG_MINUS : SEG_BLANK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= raw_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            nib_reg  <= nib_next;
            ip_reg   <= ip_next;
            neg1_reg <= raw_high[7];
        end
        if (en2)
        begin
            fbcd_reg <= fbcd_next;
            ibcd_reg <= ibcd_next;
            neg2_reg <= neg1_reg;
        end
        if (en3)
        begin
            f0_reg <= f0_next;
            f1_reg <= f1_next;
            f2_reg <= f2_next;
            f3_reg <= f3_next;
            u_reg  <= u_next;
            t_reg  <= t_next;
            h_reg  <= h_next;
            s_reg  <= s_next;
        end
    end

    assign seg_valid    = v3_reg;
    assign frac_seg_0   = f0_reg;
    assign frac_seg_1   = f1_reg;
    assign frac_seg_2   = f2_reg;
    assign frac_seg_3   = f3_reg;
    assign units_seg    = u_reg;
    assign tens_seg     = t_reg;
    assign hundreds_seg = h_reg;
    assign sign_seg     = s_reg;

`ifndef SYNTHESIS
    // The input is held back only when every stage is full and the output waits.
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        raw_stall |-> (v1_reg && v2_reg && seg_valid && seg_stall))
        else $error("input stalled while the pipeline has room");

    a_units_dp: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid |-> units_seg[0])
        else $error("units digit lost its decimal point");

    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        seg_valid |-> (sign_seg == SEG_MINUS || sign_seg == SEG_BLANK))
        else $error("bad sign pattern");

    a_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (seg_valid && tens_seg == SEG_BLANK) |-> (hundreds_seg == SEG_BLANK))
        else $error("hundreds shown while tens blanked");
`endif

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the temperature reading to seven-segment converter. Every accepted
// request is converted by an independent predictor, and each result leaving
// the block is compared field by field with the oldest pending display, while
// both handshakes are exercised with random gaps and stalls.
// ----------------------------------------------------------------------------
module tb
    import trss_pkg::*;
();

    localparam int HALF_PERIOD  = 10;
    localparam int RANDOM_ITEMS = 800;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_PRINTED  = 50;

    // Index 0 is frac_seg_0, index 7 is sign_seg.
    typedef logic [7:0][SEG_W-1:0] display_t;

    class display_scoreboard;
        display_t expected_displays[$];
        int       mismatches;
        string    field_names[8];

        function new();
            mismatches = 0;
            field_names = '{"frac_seg_0", "frac_seg_1", "frac_seg_2", "frac_seg_3",
                            "units_seg", "tens_seg", "hundreds_seg", "sign_seg"};
        endfunction

        function seg_t digit_glyph(input int d);
            seg_t g;
            case (d)
                0:       g = 8'hfc;
                1:       g = 8'h60;
                2:       g = 8'hda;
                3:       g = 8'hf2;
                4:       g = 8'h66;
                5:       g = 8'hb6;
                6:       g = 8'hbe;
                7:       g = 8'he0;
                8:       g = 8'hfe;
                default: g = 8'hf6;
            endcase
            return g;
        endfunction

        function display_t convert_reading(input logic [7:0] lo, input logic [7:0] hi);
            display_t    disp;
            logic [15:0] reading;
            logic [15:0] magnitude;
            int          frac_val;
            int          whole;
            reading   = {hi, lo};
            // The most negative reading negates to itself, as 16-bit negation does.
            magnitude = hi[7] ? 16'(-reading) : reading;
            frac_val  = int'(magnitude[3:0]) * 625;
            whole     = int'(magnitude[11:4]);
            for (int k = 0; k < 4; k++)
            begin
                disp[k]  = digit_glyph(frac_val % 10);
                frac_val = frac_val / 10;
            end
            disp[4] = digit_glyph(whole % 10) | SEG_DP;
            disp[5] = (whole >= 10) ? digit_glyph((whole / 10) % 10) : SEG_BLANK;
            disp[6] = (whole >= 100) ? digit_glyph((whole / 100) % 10) : SEG_BLANK;
            disp[7] = hi[7] ? SEG_MINUS : SEG_BLANK;
            return disp;
        endfunction

        function void note_reading(input logic [7:0] lo, input logic [7:0] hi);
            expected_displays.push_back(convert_reading(lo, hi));
        endfunction

        function int pending();
            return expected_displays.size();
        endfunction

        task report(input string msg);
            if (mismatches < MAX_PRINTED)
                $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_display(input display_t got);
            display_t want;
            if (expected_displays.size() == 0)
            begin
                report($sformatf("result with no pending request, %h", got));
                return;
            end
            want = expected_displays.pop_front();
            for (int k = 0; k < 8; k++)
                if (got[k] !== want[k])
                    report($sformatf("%s got %h expected %h", field_names[k],
                                     got[k], want[k]));
        endtask
    endclass

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             raw_valid = 1'b0;
    logic             raw_stall;
    logic [RAW_W-1:0] raw_low   = '0;
    logic [RAW_W-1:0] raw_high  = '0;
    logic             seg_valid;
    logic             seg_stall = 1'b0;
    logic [SEG_W-1:0] frac_seg_0, frac_seg_1, frac_seg_2, frac_seg_3;
    logic [SEG_W-1:0] units_seg, tens_seg, hundreds_seg, sign_seg;

    display_scoreboard sb = new();
    int                cycles = 0;
    int                burst_left = 0;

    temp_reading_to_seven_segment dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .raw_valid    (raw_valid),
        .raw_stall    (raw_stall),
        .raw_low      (raw_low),
        .raw_high     (raw_high),
        .seg_valid    (seg_valid),
        .seg_stall    (seg_stall),
        .frac_seg_0   (frac_seg_0),
        .frac_seg_1   (frac_seg_1),
        .frac_seg_2   (frac_seg_2),
        .frac_seg_3   (frac_seg_3),
        .units_seg    (units_seg),
        .tens_seg     (tens_seg),
        .hundreds_seg (hundreds_seg),
        .sign_seg     (sign_seg)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // The receiver cycles through free running, light, heavy and periodic stalling.
    always @(posedge clk)
    begin
        if (rst_n && seg_valid && !seg_stall)
            sb.check_display({sign_seg, hundreds_seg, tens_seg, units_seg,
                              frac_seg_3, frac_seg_2, frac_seg_1, frac_seg_0});
        case ((cycles / 150) % 4)
            0:       seg_stall <= 1'b0;
            1:       seg_stall <= ($urandom_range(0, 3) == 0);
            2:       seg_stall <= ($urandom_range(0, 3) != 0);
            default: seg_stall <= ((cycles % 7) < 3);
        endcase
    end

    // Requests go out in bursts; a new burst starts after a short gap.
    task automatic send_reading(input logic [15:0] reading);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 6);
            raw_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        raw_valid <= 1'b1;
        raw_low   <= reading[7:0];
        raw_high  <= reading[15:8];
        @(posedge clk);
        while (raw_stall) @(posedge clk);
        sb.note_reading(reading[7:0], reading[15:8]);
    endtask

    task automatic wait_for_empty();
        raw_valid  <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] directed[$];
        logic [15:0] reading;
        // Zero, fraction steps, blanking edges, truncated integer parts, and
        // the most negative reading.
        directed = '{16'h0000, 16'h0001, 16'h0008, 16'h000f, 16'h0090, 16'h00a0,
                     16'h0630, 16'h0640, 16'h07ff, 16'h0ff0, 16'h1000, 16'h7fff,
                     16'h8000, 16'h8001, 16'hffff, 16'hfff0, 16'hff60, 16'hfc00,
                     16'hf00f, 16'ha5a5, 16'h5a5a};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_reading(directed[i]);
        wait_for_empty();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                wait_for_empty();
            case ($urandom_range(0, 3))
                0, 1:    reading = 16'($urandom_range(0, 16'hffff));
                2:       reading = 16'($urandom_range(0, 16'h0fff));
                default: reading = 16'(17'h10000 - $urandom_range(1, 16'h0fff));
            endcase
            send_reading(reading);
        end
        raw_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// File: temp_reading_to_seven_segment.f
hdl/trss_pkg.sv
hdl/temp_reading_to_seven_segment.sv
test/tb.sv
